FILE: design/sabt_pkg.sv
// Shared types, constants and helpers of the selective-ack block tracker.
`default_nettype none

package sabt_pkg;

  // Field widths
  localparam int WORD_BITS = 32;
  localparam int BIT_W     = 5;   // bit offset inside a bitmap word
  localparam int POS_W     = 10;
  localparam int CNT_W     = 11;
  localparam int GIVE_W    = 5;
  localparam int ROUND_W   = 16;
  localparam int VALUE_W   = 32;
  localparam int SCAN_W    = 12;  // search cursor, reaches one word past the count limit
  localparam int WIDX_W    = SCAN_W - BIT_W;
  localparam int POS_WORDS = 32;  // words that a position can address

  localparam logic [GIVE_W-1:0]  EMPTY_MAX = 5'd31;
  localparam logic [ROUND_W-1:0] ROUND_MAX = 16'hFFFF;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;

  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_COUNT    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NACK_MODE      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GIVE_UP_ROUNDS = 2'd2;

  localparam logic [CNT_W-1:0]  RST_BLOCK_COUNT    = 11'd1024;
  localparam logic              RST_NACK_MODE      = 1'b0;
  localparam logic [GIVE_W-1:0] RST_GIVE_UP_ROUNDS = 5'd25;

  // Action codes of an input item
  localparam logic [1:0] ACT_ARRIVE = 2'd0;
  localparam logic [1:0] ACT_QUERY  = 2'd1;
  localparam logic [1:0] ACT_ROUND  = 2'd2;
  localparam logic [1:0] ACT_CLEAR  = 2'd3;

  typedef struct packed {
    logic [1:0]       action;
    logic [POS_W-1:0] position;
  } req_t;

  typedef struct packed {
    logic               is_new;
    logic               out_of_range;
    logic               complete;
    logic [CNT_W-1:0]   missing_count;
    logic               found;
    logic [VALUE_W-1:0] value;
    logic               give_up;
  } res_t;

  // Classified operation handed from front to back
  typedef enum logic [2:0] {
    OP_ARRIVE = 3'd0,
    OP_DROP   = 3'd1,
    OP_SACK   = 3'd2,
    OP_NACK   = 3'd3,
    OP_ROUND  = 3'd4,
    OP_CLEAR  = 3'd5
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [POS_W-1:0] position;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmdq_t;

  // Lowest set bit of a word; zero when none is set
  function automatic logic [BIT_W-1:0] first_set(input logic [WORD_BITS-1:0] v);
    logic [BIT_W-1:0] idx;
    idx = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (v[i]) idx = BIT_W'(i);
    end
    return idx;
  endfunction

endpackage

`default_nettype wire

FILE: design/sabt_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module sabt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  wire logic                                     clk,
  input  wire logic                                     we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                         wdata,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: design/sabt_fifo.sv
// Small register queue with push/full and pop/empty sides.
`default_nettype none

module sabt_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  output logic                  full,
  input  wire logic             pop,
  output logic      [WIDTH-1:0] rdata,
  output logic                  empty
);

  localparam int PW = DEPTH > 1 ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full    = count == CW'(DEPTH);
  assign empty   = count == '0;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= wdata;
  end

endmodule

`default_nettype wire

FILE: design/sabt_front.sv
// Front end: takes input beats, classifies them and queues commands for the engine.
`default_nettype none

module sabt_front import sabt_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  output logic                  full,
  input  wire req_t             request,
  input  wire logic [CNT_W-1:0] used_count,
  input  wire logic             nack_mode,
  input  wire logic             cmd_pop,
  output cmdq_t                 cmdq
);

  cmd_t cmd_in;
  cmd_t cmd_head;
  logic cmd_empty;

  always_comb begin
    cmd_in.position = request.position;
    case (request.action)
      ACT_ARRIVE: cmd_in.op = ({1'b0, request.position} >= used_count) ? OP_DROP : OP_ARRIVE;
      ACT_QUERY:  cmd_in.op = nack_mode ? OP_NACK : OP_SACK;
      ACT_ROUND:  cmd_in.op = OP_ROUND;
      ACT_CLEAR:  cmd_in.op = OP_CLEAR;
      default:    cmd_in.op = OP_CLEAR;
    endcase
  end

  sabt_fifo #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (2)
  ) u_cmd_q (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (cmd_in),
    .full  (full),
    .pop   (cmd_pop),
    .rdata (cmd_head),
    .empty (cmd_empty)
  );

  assign cmdq.valid = !cmd_empty;
  assign cmdq.cmd   = cmd_head;

endmodule

`default_nettype wire

FILE: design/sabt_back.sv
// Back end: bitmap engine that runs one command at a time and emits its result beat.
`default_nettype none

module sabt_back import sabt_pkg::*; #(
  parameter int MAX_BLOCKS = 1024
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire cmdq_t             cmdq,
  output logic                   cmd_pop,
  input  wire logic [CNT_W-1:0]  used_count,
  input  wire logic [GIVE_W-1:0] give_up_rounds,
  input  wire logic              out_full,
  output logic                   out_push,
  output res_t                   out_data
);

  localparam int MAP_WORDS   = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
  // Words past the position range are never marked and always read as zero
  localparam int STORE_WORDS = MAP_WORDS < POS_WORDS ? MAP_WORDS : POS_WORDS;
  localparam int WAW         = STORE_WORDS > 1 ? $clog2(STORE_WORDS) : 1;

  typedef enum logic [5:0] {
    ST_IDLE     = 6'b000001,
    ST_RMW      = 6'b000010,
    ST_SACK     = 6'b000100,
    ST_SCAN_RD  = 6'b001000,
    ST_SCAN_CHK = 6'b010000,
    ST_EMIT     = 6'b100000
  } state_t;

  state_t                   state, state_next;
  cmd_t                     cur, cur_next;
  res_t                     res, res_next;
  logic [STORE_WORDS-1:0]   valid, valid_next;
  logic [CNT_W-1:0]         unique_received, unique_received_next;
  logic [ROUND_W-1:0]       round_arrivals, round_arrivals_next;
  logic [GIVE_W-1:0]        empty_rounds, empty_rounds_next;
  logic [SCAN_W-1:0]        scan_idx, scan_idx_next;
  logic [WAW-1:0]           rd_addr, rd_addr_next;

  logic                     ram_we;
  logic [WORD_BITS-1:0]     ram_wdata;
  logic [WORD_BITS-1:0]     ram_rdata;
  logic [WORD_BITS-1:0]     word_rd;
  logic [WORD_BITS-1:0]     bit_mask;
  logic [WORD_BITS-1:0]     open_bits;
  logic [SCAN_W-1:0]        cand;
  logic [SCAN_W-1:0]        scan_limit;
  logic [WIDX_W-1:0]        scan_word;
  logic [CNT_W-1:0]         missing;
  logic [GIVE_W-1:0]        empty_step;

  assign missing    = (used_count > unique_received) ? used_count - unique_received : '0;
  assign word_rd    = valid[rd_addr] ? ram_rdata : '0;
  assign bit_mask   = WORD_BITS'(1) << cur.position[BIT_W-1:0];
  assign scan_word  = scan_idx[SCAN_W-1:BIT_W];
  assign scan_limit = {1'b0, used_count};
  assign open_bits  = ~word_rd & ({WORD_BITS{1'b1}} << scan_idx[BIT_W-1:0]);
  assign cand       = {scan_word, first_set(open_bits)};
  assign empty_step = (round_arrivals != '0) ? '0 :
                      (empty_rounds == EMPTY_MAX) ? EMPTY_MAX : empty_rounds + 1'b1;

  sabt_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (STORE_WORDS)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (rd_addr),
    .wdata (ram_wdata),
    .raddr (rd_addr_next),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_next           = state;
    cur_next             = cur;
    res_next             = res;
    valid_next           = valid;
    unique_received_next = unique_received;
    round_arrivals_next  = round_arrivals;
    empty_rounds_next    = empty_rounds;
    scan_idx_next        = scan_idx;
    rd_addr_next         = rd_addr;
    cmd_pop              = 1'b0;
    out_push             = 1'b0;
    ram_we               = 1'b0;
    ram_wdata            = word_rd | bit_mask;

    case (state)
      ST_IDLE: begin
        if (cmdq.valid) begin
          cmd_pop  = 1'b1;
          cur_next = cmdq.cmd;
          res_next = '0;
          case (cmdq.cmd.op)
            OP_ARRIVE: begin
              rd_addr_next = cmdq.cmd.position[BIT_W +: WAW];
              state_next   = ST_RMW;
            end
            OP_DROP: begin
              res_next.out_of_range = 1'b1;
              state_next            = ST_EMIT;
            end
            OP_SACK: begin
              if (cmdq.cmd.position < POS_W'(STORE_WORDS)) begin
                rd_addr_next = cmdq.cmd.position[WAW-1:0];
                state_next   = ST_SACK;
              end else begin
                state_next = ST_EMIT;
              end
            end
            OP_NACK: begin
              scan_idx_next = SCAN_W'(cmdq.cmd.position);
              state_next    = (missing == '0) ? ST_EMIT : ST_SCAN_RD;
            end
            OP_ROUND: begin
              empty_rounds_next   = empty_step;
              round_arrivals_next = '0;
              res_next.give_up    = empty_step >= give_up_rounds;
              state_next          = ST_EMIT;
            end
            OP_CLEAR: begin
              valid_next           = '0;
              unique_received_next = '0;
              round_arrivals_next  = '0;
              empty_rounds_next    = '0;
              state_next           = ST_EMIT;
            end
            default: state_next = ST_EMIT;
          endcase
        end
      end

      ST_RMW: begin
        if ((word_rd & bit_mask) == '0) begin
          ram_we               = 1'b1;
          valid_next[rd_addr]  = 1'b1;
          unique_received_next = unique_received + 1'b1;
          res_next.is_new      = 1'b1;
        end
        if (round_arrivals != ROUND_MAX) round_arrivals_next = round_arrivals + 1'b1;
        state_next = ST_EMIT;
      end

      ST_SACK: begin
        res_next.value = word_rd;
        state_next     = ST_EMIT;
      end

      ST_SCAN_RD: begin
        if (scan_idx >= scan_limit) begin
          state_next = ST_EMIT;
        end else if (scan_word >= WIDX_W'(STORE_WORDS)) begin
          // never-marked word: this index is missing
          res_next.found = 1'b1;
          res_next.value = VALUE_W'(scan_idx);
          state_next     = ST_EMIT;
        end else begin
          rd_addr_next = scan_idx[BIT_W +: WAW];
          state_next   = ST_SCAN_CHK;
        end
      end

      ST_SCAN_CHK: begin
        if (open_bits != '0) begin
          if (cand < scan_limit) begin
            res_next.found = 1'b1;
            res_next.value = VALUE_W'(cand);
          end
          state_next = ST_EMIT;
        end else begin
          // advance to the start of the next word
          scan_idx_next = {scan_word + 1'b1, {BIT_W{1'b0}}};
          state_next    = ST_SCAN_RD;
        end
      end

      ST_EMIT: begin
        out_push = !out_full;
        if (!out_full) state_next = ST_IDLE;
      end

      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    out_data               = res;
    out_data.complete      = missing == '0;
    out_data.missing_count = missing;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      valid           <= '0;
      unique_received <= '0;
      round_arrivals  <= '0;
      empty_rounds    <= '0;
    end else begin
      state           <= state_next;
      valid           <= valid_next;
      unique_received <= unique_received_next;
      round_arrivals  <= round_arrivals_next;
      empty_rounds    <= empty_rounds_next;
    end
  end

  always_ff @(posedge clk) begin
    cur      <= cur_next;
    res      <= res_next;
    scan_idx <= scan_idx_next;
    rd_addr  <= rd_addr_next;
  end

endmodule

`default_nettype wire

FILE: design/selective_ack_block_tracker_core.sv
// Top level of the selective-ack block tracker: config registers, front, engine, result queue.
//
//   channel   direction  handshake            payload
//   request   in         push / full         req_t  (action, position)
//   result    out        empty / pop         res_t  (is_new .. give_up)
//   cfg       in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// Round ends, clears, out-of-range arrivals, SACK past the bitmap and NACK with nothing
// missing go from idle straight to emit; other arrivals and SACK queries pass one bitmap
// read state first; a NACK query reads and checks bitmap words until a gap or the block count.
// A full result queue holds the engine in its emit state.
// Reset clears all control state and the bitmap valid bits.
// A two-entry command queue and a two-entry result queue let input and output stall apart.
`default_nettype none

module selective_ack_block_tracker_core import sabt_pkg::*; #(
  parameter int MAX_BLOCKS = 1024
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  push,
  output logic                       full,
  input  wire req_t                  request,
  output logic                       empty,
  input  wire logic                  pop,
  output res_t                       result,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int CAP = MAX_BLOCKS < 2047 ? MAX_BLOCKS : 2047;
  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAP);

  logic [CNT_W-1:0]  block_count;
  logic              nack_mode;
  logic [GIVE_W-1:0] give_up_rounds;
  logic [CNT_W-1:0]  used_count;

  cmdq_t cmdq;
  logic  cmd_pop;
  logic  out_push;
  logic  out_full;
  res_t  out_data;
  res_t  out_head;

  assign cfg_ready  = 1'b1;
  assign used_count = (block_count < CAP_CNT) ? block_count : CAP_CNT;

  always_ff @(posedge clk) begin
    if (rst) begin
      block_count    <= RST_BLOCK_COUNT;
      nack_mode      <= RST_NACK_MODE;
      give_up_rounds <= RST_GIVE_UP_ROUNDS;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_BLOCK_COUNT:    block_count    <= cfg_data;
        REG_NACK_MODE:      nack_mode      <= cfg_data[0];
        REG_GIVE_UP_ROUNDS: give_up_rounds <= cfg_data[GIVE_W-1:0];
        default:            block_count    <= block_count;
      endcase
    end
  end

  sabt_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .request    (request),
    .used_count (used_count),
    .nack_mode  (nack_mode),
    .cmd_pop    (cmd_pop),
    .cmdq       (cmdq)
  );

  sabt_back #(
    .MAX_BLOCKS (MAX_BLOCKS)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .cmdq           (cmdq),
    .cmd_pop        (cmd_pop),
    .used_count     (used_count),
    .give_up_rounds (give_up_rounds),
    .out_full       (out_full),
    .out_push       (out_push),
    .out_data       (out_data)
  );

  sabt_fifo #(
    .WIDTH ($bits(res_t)),
    .DEPTH (2)
  ) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (out_push),
    .wdata (out_data),
    .full  (out_full),
    .pop   (pop),
    .rdata (out_head),
    .empty (empty)
  );

  assign result = out_head;

endmodule

`default_nettype wire
